@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the range filter modules
// each macro expects clk_i and rst_ni in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ rtl/core/urmf_pkg.sv @@
// types, constants and helpers of the ultrasonic range median filter
// no dependencies
`default_nettype none

package urmf_pkg;

  // echo sample width and conversion constants
  localparam int EchoWidth  = 16;
  localparam int XWidth     = EchoWidth + 5;        // us * 17
  localparam int CmWidth    = 10;
  localparam int CmDivisor  = 1000;
  localparam int LimitCm    = 400;
  localparam int NoObstacle = 999;
  localparam int LimitX     = (LimitCm + 1) * CmDivisor;
  localparam int MulWidth   = $clog2(LimitX);
  localparam int RecipShift = 29;
  localparam int Recip      = ((1 << RecipShift) + CmDivisor - 1) / CmDivisor;
  localparam int RecipWidth = $clog2(Recip);
  localparam int ProdWidth  = MulWidth + RecipWidth;

  // batch layout
  localparam int SensorCnt  = 3;
  localparam int BatchLen   = 3 * SensorCnt;
  localparam int StoreDepth = BatchLen - 1;
  localparam int StoreIdxW  = $clog2(StoreDepth);
  localparam int PosWidth   = $clog2(BatchLen + 1);
  localparam int LastPos    = BatchLen - 1;

  // queue between front and back
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  // configuration
  localparam int OffsetWidth = 10;
  localparam int MaxWidth    = 9;
  localparam int ActiveWidth = 2;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 10;
  localparam int MaxReset    = 400;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgOffset   = 2'd0,
    CfgMaxRange = 2'd1,
    CfgActive   = 2'd2
  } cfg_idx_e;

  typedef enum logic [ActiveWidth-1:0] {
    ActAll    = 2'd0,
    ActLeft   = 2'd1,
    ActCenter = 2'd2,
    ActRight  = 2'd3
  } active_e;

  typedef logic [CmWidth-1:0] cm_t;

  typedef struct packed {
    cm_t [BatchLen-1:0] sample;
  } batch_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // median of three
  function automatic cm_t mid3(cm_t a, cm_t b, cm_t c);
    cm_t lo;
    cm_t hi;
    cm_t hc;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hc = (hi < c) ? hi : c;
    return (lo > hc) ? lo : hc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/urmf_front.sv @@
// front end: accepts echo beats, converts to centimetres, gathers a batch
// depends on urmf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module urmf_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [15:0]                    echo_us_i,
  input  urmf_pkg::fifo_status_t              fifo_status_i,
  output logic                                fifo_push_o,
  output urmf_pkg::batch_t                    fifo_wdata_o
);

  logic                              accept;
  logic [31:0]                       echo_ext;
  logic [urmf_pkg::EchoWidth-1:0]    us;
  logic [urmf_pkg::PosWidth-1:0]     pos_q, pos_d;
  logic                              s1_valid_q, s1_valid_d;
  logic [urmf_pkg::XWidth-1:0]       s1_x_q;
  logic                              s1_zero_q;
  logic [urmf_pkg::PosWidth-1:0]     s1_pos_q;
  logic                              s1_last;
  logic                              s1_go;
  logic [31:0]                       x_ext;
  logic [urmf_pkg::MulWidth-1:0]     mul_in;
  logic [urmf_pkg::ProdWidth-1:0]    prod;
  urmf_pkg::cm_t                     cm;
  urmf_pkg::cm_t                     store_q [urmf_pkg::StoreDepth];

  // input handshake
  assign s1_last     = (s1_pos_q == urmf_pkg::PosWidth'(urmf_pkg::LastPos));
  assign full        = s1_valid_q && s1_last && fifo_status_i.full;
  assign accept      = push && !full;
  assign s1_go       = s1_valid_q && !(s1_last && fifo_status_i.full);
  assign fifo_push_o = s1_valid_q && s1_last && !fifo_status_i.full;

  assign echo_ext = 32'(echo_us_i);
  assign us       = echo_ext[urmf_pkg::EchoWidth-1:0];

  // batch position
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q >= urmf_pkg::PosWidth'(urmf_pkg::LastPos)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // first stage: times 17 as shift and add
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= {us, 4'b0000} + urmf_pkg::XWidth'(us);
      s1_zero_q <= (us == '0);
      s1_pos_q  <= (pos_q >= urmf_pkg::PosWidth'(urmf_pkg::LastPos)) ?
                   urmf_pkg::PosWidth'(urmf_pkg::LastPos) : pos_q;
    end
  end

  // second stage: divide by 1000 through the reciprocal, range check
  assign x_ext  = 32'(s1_x_q);
  assign mul_in = x_ext[urmf_pkg::MulWidth-1:0];
  assign prod   = urmf_pkg::ProdWidth'(mul_in) *
                  urmf_pkg::ProdWidth'(urmf_pkg::Recip);

  always_comb begin
    if (s1_zero_q || (x_ext >= 32'(urmf_pkg::LimitX))) begin
      cm = urmf_pkg::CmWidth'(urmf_pkg::NoObstacle);
    end else begin
      cm = prod[urmf_pkg::RecipShift +: urmf_pkg::CmWidth];
    end
  end

  // sample store, first eight beats of a batch
  always_ff @(posedge clk_i) begin
    if (s1_go && !s1_last) begin
      store_q[s1_pos_q[urmf_pkg::StoreIdxW-1:0]] <= cm;
    end
  end

  // complete batch towards the queue
  always_comb begin
    for (int i = 0; i < urmf_pkg::StoreDepth; i++) begin
      fifo_wdata_o.sample[i] = store_q[i];
    end
    fifo_wdata_o.sample[urmf_pkg::LastPos] = cm;
  end

  `ASSERT_PROP(a_pos_range, pos_q <= urmf_pkg::PosWidth'(urmf_pkg::LastPos),
               "batch position out of range")
  `ASSERT_PROP(a_stall_hold, s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_x_q)
               && $stable(s1_pos_q), "stalled conversion stage lost its beat")

endmodule

`default_nettype wire

@@ rtl/core/urmf_batch_fifo.sv @@
// two-entry queue of complete batches between front and back
// depends on urmf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module urmf_batch_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  urmf_pkg::batch_t       wdata_i,
  input  wire logic              pop_i,
  output urmf_pkg::batch_t       rdata_o,
  output urmf_pkg::fifo_status_t status_o
);

  urmf_pkg::batch_t                 entry_q [urmf_pkg::FifoDepth];
  logic [urmf_pkg::FifoPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [urmf_pkg::FifoPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [urmf_pkg::FifoCntW-1:0]    count_q, count_d;
  logic                             do_push;
  logic                             do_pop;

  assign status_o.full  = (count_q == urmf_pkg::FifoCntW'(urmf_pkg::FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = entry_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == urmf_pkg::FifoPtrW'(urmf_pkg::FifoDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == urmf_pkg::FifoPtrW'(urmf_pkg::FifoDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ASSERT_PROP(a_count_range, count_q <= urmf_pkg::FifoCntW'(urmf_pkg::FifoDepth),
               "batch queue count overflow")
  `ASSERT_PROP(a_ptr_gap, status_o.empty |-> wr_ptr_q == rd_ptr_q,
               "empty batch queue with pointers apart")

endmodule

`default_nettype wire

@@ rtl/core/urmf_back.sv @@
// back end: median of three per sensor, calibration, sensor select, result beat
// depends on urmf_pkg
`default_nettype none

module urmf_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [urmf_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire logic [urmf_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  urmf_pkg::fifo_status_t                    fifo_status_i,
  input  urmf_pkg::batch_t                          fifo_rdata_i,
  output logic                                      fifo_pop_o,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [urmf_pkg::CmWidth-1:0]              left_cm_o,
  output logic [urmf_pkg::CmWidth-1:0]              center_cm_o,
  output logic [urmf_pkg::CmWidth-1:0]              right_cm_o
);

  logic signed [urmf_pkg::OffsetWidth-1:0] offset_q;
  logic [urmf_pkg::MaxWidth-1:0]           max_q;
  urmf_pkg::active_e                       active_q;
  logic                                    out_valid_q, out_valid_d;
  logic                                    take;
  urmf_pkg::cm_t                           res [urmf_pkg::SensorCnt];
  urmf_pkg::cm_t                           out_q [urmf_pkg::SensorCnt];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      max_q    <= urmf_pkg::MaxWidth'(urmf_pkg::MaxReset);
      active_q <= urmf_pkg::ActAll;
    end else if (cfg_we_i) begin
      case (urmf_pkg::cfg_idx_e'(cfg_idx_i))
        urmf_pkg::CfgOffset: begin
          offset_q <= cfg_wdata_i[urmf_pkg::OffsetWidth-1:0];
        end
        urmf_pkg::CfgMaxRange: begin
          max_q <= cfg_wdata_i[urmf_pkg::MaxWidth-1:0];
        end
        urmf_pkg::CfgActive: begin
          active_q <= urmf_pkg::active_e'(cfg_wdata_i[urmf_pkg::ActiveWidth-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // median, calibration and sensor select per sensor
  always_comb begin
    urmf_pkg::cm_t      med;
    logic signed [11:0] sum;
    logic               sel;
    for (int s = 0; s < urmf_pkg::SensorCnt; s++) begin
      med = urmf_pkg::mid3(fifo_rdata_i.sample[s],
                           fifo_rdata_i.sample[s + urmf_pkg::SensorCnt],
                           fifo_rdata_i.sample[s + 2 * urmf_pkg::SensorCnt]);
      sum = $signed({2'b00, med}) + 12'(offset_q);
      sel = (active_q == urmf_pkg::ActAll) ||
            (32'(active_q) == 32'(s + 1));
      if (!sel) begin
        res[s] = urmf_pkg::CmWidth'(urmf_pkg::NoObstacle);
      end else if (med == urmf_pkg::CmWidth'(urmf_pkg::NoObstacle)) begin
        res[s] = med;
      end else if (sum < 0) begin
        res[s] = '0;
      end else if (sum > $signed({3'b000, max_q})) begin
        res[s] = urmf_pkg::CmWidth'(urmf_pkg::NoObstacle);
      end else begin
        res[s] = sum[urmf_pkg::CmWidth-1:0];
      end
    end
  end

  // result register handshake
  assign empty       = !out_valid_q;
  assign take        = !fifo_status_i.empty && (!out_valid_q || pop);
  assign fifo_pop_o  = take;
  assign out_valid_d = take || (out_valid_q && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int s = 0; s < urmf_pkg::SensorCnt; s++) begin
        out_q[s] <= res[s];
      end
    end
  end

  assign left_cm_o   = out_q[0];
  assign center_cm_o = out_q[1];
  assign right_cm_o  = out_q[2];

endmodule

`default_nettype wire

@@ rtl/core/ultrasonic_range_median_filter_top.sv @@
// one echo beat per cycle while full is low; a result beat for every ninth echo of a batch
// the ninth echo reaches empty low through the conversion stage, then the batch
// queue, into the median and calibration register
// the batch queue holds two batches; input stalls once both wait behind a result
// reset clears batch position, queues and registers (offset 0, max 400, all)
// the sample store is not cleared; each batch writes it before reading it
`default_nettype none

module ultrasonic_range_median_filter_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [15:0]                       echo_us_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [9:0]                             left_cm_o,
  output logic [9:0]                             center_cm_o,
  output logic [9:0]                             right_cm_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [urmf_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [urmf_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  urmf_pkg::fifo_status_t fifo_status;
  urmf_pkg::batch_t       fifo_wdata;
  urmf_pkg::batch_t       fifo_rdata;
  logic                   fifo_push;
  logic                   fifo_pop;

  // intake and conversion
  urmf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .echo_us_i     (echo_us_i),
    .fifo_status_i (fifo_status),
    .fifo_push_o   (fifo_push),
    .fifo_wdata_o  (fifo_wdata)
  );

  // batch queue
  urmf_batch_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .wdata_i  (fifo_wdata),
    .pop_i    (fifo_pop),
    .rdata_o  (fifo_rdata),
    .status_o (fifo_status)
  );

  // filtering and result
  urmf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_status_i (fifo_status),
    .fifo_rdata_i  (fifo_rdata),
    .fifo_pop_o    (fifo_pop),
    .empty         (empty),
    .pop           (pop),
    .left_cm_o     (left_cm_o),
    .center_cm_o   (center_cm_o),
    .right_cm_o    (right_cm_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/ultrasonic_range_median_filter_top_tb.sv @@
// self-checking testbench of the ultrasonic range median filter top level
// depends on urmf_pkg and ultrasonic_range_median_filter_top
`timescale 1ns / 1ps

module ultrasonic_range_median_filter_top_tb;

  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 8;
  localparam int ECHOS_PER_PHASE = 175;
  localparam int DIR_ROWS       = 22;
  localparam int MAX_REPORTS    = 10;
  localparam urmf_pkg::cm_t NO_OBS = urmf_pkg::cm_t'(999);
  localparam int FAR_CM         = 400;

  typedef struct packed {
    urmf_pkg::cm_t left;
    urmf_pkg::cm_t center;
    urmf_pkg::cm_t right;
  } range_t;

  typedef struct packed {
    logic [15:0] echo;
    logic        typed;
    range_t      want;
  } dir_row_t;

  localparam range_t NO_RANGE  = '0;
  localparam range_t ALL_CLEAR = '{NO_OBS, NO_OBS, NO_OBS};

  // block ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [15:0] echo_us_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [9:0]  left_cm_o;
  logic [9:0]  center_cm_o;
  logic [9:0]  right_cm_o;
  logic        cfg_we_i    = 1'b0;
  logic [urmf_pkg::CfgIdxWidth-1:0]  cfg_idx_i   = '0;
  logic [urmf_pkg::CfgDataWidth-1:0] cfg_wdata_i = '0;

  // shadow of the block: samples of the batch, position and registers
  urmf_pkg::cm_t     sample_sh [urmf_pkg::BatchLen];
  int                batch_pos = 0;
  logic signed [9:0] offset_sh = '0;
  logic [8:0]        max_sh    = 9'd400;
  urmf_pkg::active_e active_sh = urmf_pkg::ActAll;

  range_t pending_ranges [$];
  int     fail_cnt    = 0;
  int     idle_cycles = 0;
  bit     tx_quiet    = 1'b0;
  bit     hold_req    = 1'b0;
  bit     hold_taken  = 1'b0;
  int     rx_stall    = 0;

  ultrasonic_range_median_filter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .echo_us_i   (echo_us_i),
    .empty       (empty),
    .pop         (pop),
    .left_cm_o   (left_cm_o),
    .center_cm_o (center_cm_o),
    .right_cm_o  (right_cm_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // echo length to centimetres, zero and far echoes read as no obstacle
  function automatic urmf_pkg::cm_t echo_to_cm(logic [15:0] us);
    logic [31:0] echo_bits;
    logic [31:0] range_cm;
    echo_bits = 32'(us) & ((32'd1 << urmf_pkg::EchoWidth) - 32'd1);
    if (echo_bits == '0) return NO_OBS;
    range_cm = (echo_bits * 32'd17) / 32'd1000;
    if (range_cm > FAR_CM) return NO_OBS;
    return urmf_pkg::cm_t'(range_cm);
  endfunction

  // compare-and-swap network, middle value survives
  function automatic urmf_pkg::cm_t median_of_three(urmf_pkg::cm_t a, urmf_pkg::cm_t b,
                                                    urmf_pkg::cm_t c);
    urmf_pkg::cm_t t;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return b;
  endfunction

  // offset, clamp at zero, range limit
  function automatic urmf_pkg::cm_t apply_offset(urmf_pkg::cm_t cm);
    logic signed [11:0] sum;
    if (cm == NO_OBS) return cm;
    sum = $signed({2'b00, cm}) + offset_sh;
    if (sum < 0) sum = '0;
    if (sum > $signed({3'b000, max_sh})) return NO_OBS;
    return urmf_pkg::cm_t'(sum[9:0]);
  endfunction

  // store one echo; a full batch yields the filtered ranges
  function automatic bit take_echo(logic [15:0] us, output range_t ranges);
    urmf_pkg::cm_t val [3];
    sample_sh[batch_pos] = echo_to_cm(us);
    ranges = NO_RANGE;
    if (batch_pos < urmf_pkg::BatchLen - 1) begin
      batch_pos++;
      return 1'b0;
    end
    batch_pos = 0;
    for (int s = 0; s < urmf_pkg::SensorCnt; s++) begin
      val[s] = apply_offset(median_of_three(sample_sh[s], sample_sh[s + 3],
                                            sample_sh[s + 6]));
      if (active_sh != urmf_pkg::ActAll && int'(active_sh) != s + 1) val[s] = NO_OBS;
    end
    ranges = '{val[0], val[1], val[2]};
    return 1'b1;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // echo lengths weighted towards the measurable span and its edges
  function automatic logic [15:0] pick_echo();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return 16'($urandom);
      3:       return 16'($urandom_range(23570, 23610));
      4:       return 16'($urandom_range(1, 70));
      default: return 16'($urandom_range(59, 23588));
    endcase
  endfunction

  // one echo beat; waits for acceptance, leaves push high
  task automatic send_echo(input logic [15:0] us, input logic typed, input range_t want);
    range_t ranges;
    push      <= 1'b1;
    echo_us_i <= us;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (take_echo(us, ranges)) pending_ranges.push_back(typed ? want : ranges);
  endtask

  task automatic idle_tx(input int n);
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop sending, wait for every outstanding range and for the pipeline
  task automatic drain_results();
    push <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; enable is left high for back-to-back writes
  task automatic write_reg(input urmf_pkg::cfg_idx_e idx, input logic [9:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      urmf_pkg::CfgOffset:   offset_sh = $signed(data);
      urmf_pkg::CfgMaxRange: max_sh    = data[8:0];
      urmf_pkg::CfgActive:   active_sh = urmf_pkg::active_e'(data[1:0]);
      default: ;
    endcase
  endtask

  // settings per phase: extremes first, then random, unused bits set now and then
  task automatic program_phase(input int p);
    logic [9:0] off_w;
    logic [9:0] max_w;
    logic [9:0] act_w;
    case (p)
      1: begin
        off_w = 10'(-400);
        max_w = 10'h200 | 10'd400;
        act_w = {8'hff, urmf_pkg::ActLeft};
      end
      2: begin
        off_w = 10'd400;
        max_w = 10'd0;
        act_w = {8'h00, urmf_pkg::ActCenter};
      end
      3: begin
        off_w = 10'(-1);
        max_w = 10'd400;
        act_w = {8'h5a, urmf_pkg::ActRight};
      end
      4: begin
        off_w = 10'd0;
        max_w = 10'd200;
        act_w = {8'h00, urmf_pkg::ActAll};
      end
      default: begin
        off_w = 10'(int'($urandom_range(0, 800)) - 400);
        max_w = {1'($urandom), 9'($urandom_range(0, 400))};
        act_w = {8'($urandom), 2'($urandom_range(0, 3))};
      end
    endcase
    write_reg(urmf_pkg::CfgOffset, off_w);
    write_reg(urmf_pkg::CfgMaxRange, max_w);
    write_reg(urmf_pkg::CfgActive, act_w);
    cfg_we_i <= 1'b0;
  endtask

  // result side: check each beat, random stalls, one long hold-off
  always @(posedge clk_i) begin
    range_t got;
    range_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = '{left_cm_o, center_cm_o, right_cm_o};
        if (pending_ranges.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected range beat: %0d/%0d/%0d", got.left, got.center, got.right);
        end else begin
          want = pending_ranges.pop_front();
          if (got.left !== want.left || got.center !== want.center
              || got.right !== want.right) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("range beat differs: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.left, want.center, want.right,
                       got.left, got.center, got.right);
          end
        end
        rx_stall = tx_quiet ? 0 : pick_gap();
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        rx_stall   = LONG_HOLD;
      end
      if (rx_stall != 0) begin
        pop <= 1'b0;
        rx_stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ultrasonic_range_median_filter_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus: directed rows, then random phases under changing settings
  initial begin : stimulus
    dir_row_t rows [DIR_ROWS];
    rows = '{
      // all timeouts with reset settings: no obstacle on every side
      '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE},
      '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE},
      '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE}, '{16'd0, 1'b1, ALL_CLEAR},
      // left near zero, centre at the 400 cm edge, right too far or timed out
      '{16'd1, 1'b0, NO_RANGE}, '{16'd23588, 1'b0, NO_RANGE}, '{16'd65535, 1'b0, NO_RANGE},
      '{16'd58, 1'b0, NO_RANGE}, '{16'd23588, 1'b0, NO_RANGE}, '{16'd0, 1'b0, NO_RANGE},
      '{16'd59, 1'b0, NO_RANGE}, '{16'd23589, 1'b0, NO_RANGE},
      '{16'd32768, 1'b1, '{urmf_pkg::cm_t'(0), urmf_pkg::cm_t'(400), NO_OBS}},
      // partial batch, finished by the random beats that follow
      '{16'h5555, 1'b0, NO_RANGE}, '{16'haaaa, 1'b0, NO_RANGE},
      '{16'h0001, 1'b0, NO_RANGE}, '{16'h7fff, 1'b0, NO_RANGE}
    };
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_echo(rows[i].echo, rows[i].typed, rows[i].want);
      idle_tx(pick_gap());
    end
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        program_phase(p);
      end
      tx_quiet = (p == 2) || (p == 5);
      if (p == 2) hold_req = 1'b1;
      repeat ((p == 0) ? ECHOS_PER_PHASE - DIR_ROWS : ECHOS_PER_PHASE) begin
        send_echo(pick_echo(), 1'b0, NO_RANGE);
        if (!tx_quiet) idle_tx(pick_gap());
      end
    end
    drain_results();
    if (fail_cnt == 0) begin
      $display("ultrasonic_range_median_filter_top: match");
    end else begin
      $display("ultrasonic_range_median_filter_top: mismatch");
    end
    $finish;
  end

endmodule
